// ----- hdl/srtl_pkg.sv -----
package srtl_pkg;

   // Command codes carried by req_command
   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_LOAD   = 2'd1,
      CMD_SORT   = 2'd2,
      CMD_LOOKUP = 2'd3
   } cmd_type;

   // Status codes carried by rsp_status
   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SORT_CUR,
      ST_SORT_CMP,
      ST_SORT_WB,
      ST_LOOK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [31:0] key;
      logic [15:0] tag;
      logic [15:0] quantity;
      logic [31:0] payment;
   } record_type;

   localparam int REC_W = $bits(record_type);

   typedef struct packed {
      status_type status;
      record_type rec;
   } res_type;

endpackage

// ----- hdl/srtl_ram.sv -----
module srtl_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/srtl_seq.sv -----
module srtl_seq #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_command,
   input  logic signed [31:0]              req_order_key,
   input  logic [15:0]                     req_record_tag,
   input  logic [15:0]                     req_quantity,
   input  logic [31:0]                     req_payment,
   output logic                            res_valid,
   input  logic                            res_ready,
   output srtl_pkg::res_type               res,
   output logic                            ram_we,
   output logic [$clog2(TABLE_DEPTH)-1:0]  ram_waddr,
   output logic [srtl_pkg::REC_W-1:0]      ram_wdata,
   output logic [$clog2(TABLE_DEPTH)-1:0]  ram_raddr,
   input  logic [srtl_pkg::REC_W-1:0]      ram_rdata
);
   import srtl_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     i_ff, i_in;
   logic [IDX_W-1:0]     k_ff, k_in;
   record_type           cur_ff, cur_in;
   logic [CNT_W-1:0]     lo_ff, lo_in;
   logic [CNT_W-1:0]     hi_ff, hi_in;
   logic [IDX_W-1:0]     mid_ff, mid_in;
   logic [31:0]          key_ff, key_in;
   res_type              res_ff, res_in;

   record_type           rd_rec;
   cmd_type              cmd;
   logic [CNT_W-1:0]     cnt_m1;
   logic [CNT_W-1:0]     cnt_m2;
   logic                 sort_swap;
   logic                 sort_last_k;
   logic                 sort_last_i;
   logic                 look_hit;
   logic                 look_more;
   logic [CNT_W-1:0]     lo_nx;
   logic [CNT_W-1:0]     hi_nx;
   logic [CNT_W:0]       mid_sum;
   logic [CNT_W:0]       first_sum;

   assign rd_rec = record_type'(ram_rdata);
   assign cmd    = cmd_type'(req_command);
   assign cnt_m1 = count_ff - CNT_W'(1);
   assign cnt_m2 = count_ff - CNT_W'(2);

   // probe and compare logic shared by next-state and datapath
   always_comb begin
      sort_swap   = $signed(cur_ff.key) > $signed(rd_rec.key);
      sort_last_k = (k_ff == cnt_m1[IDX_W-1:0]);
      sort_last_i = (i_ff == cnt_m2[IDX_W-1:0]);
      look_hit    = (rd_rec.key == key_ff);
      if ($signed(rd_rec.key) > $signed(key_ff)) begin
         lo_nx = lo_ff;
         hi_nx = CNT_W'(mid_ff);
      end else begin
         lo_nx = CNT_W'(mid_ff) + CNT_W'(1);
         hi_nx = hi_ff;
      end
      look_more = (lo_nx < hi_nx);
      mid_sum   = {1'b0, lo_nx} + {1'b0, hi_nx} - (CNT_W + 1)'(1);
      first_sum = {1'b0, cnt_m1};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (cmd)
                  CMD_CLEAR, CMD_LOAD: state_in = ST_RESP;
                  CMD_SORT:   state_in = (count_ff < CNT_W'(2)) ? ST_RESP : ST_SORT_CUR;
                  CMD_LOOKUP: state_in = (count_ff == '0) ? ST_RESP : ST_LOOK;
               endcase
            end
         end
         ST_SORT_CUR: state_in = ST_SORT_CMP;
         ST_SORT_CMP: state_in = sort_last_k ? ST_SORT_WB : ST_SORT_CMP;
         ST_SORT_WB:  state_in = sort_last_i ? ST_RESP : ST_SORT_CUR;
         ST_LOOK:     state_in = (look_hit || !look_more) ? ST_RESP : ST_LOOK;
         ST_RESP:     state_in = res_ready ? ST_IDLE : ST_RESP;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      count_in  = count_ff;
      i_in      = i_ff;
      k_in      = k_ff;
      cur_in    = cur_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      key_in    = key_ff;
      res_in    = res_ff;
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = REC_W'(cur_ff);
      ram_raddr = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_in        = '0;
               res_in.status = STAT_OK;
               unique case (cmd)
                  CMD_CLEAR: count_in = '0;
                  CMD_LOAD: begin
                     if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                        res_in.status = STAT_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = count_ff[IDX_W-1:0];
                        ram_wdata = {req_order_key, req_record_tag, req_quantity, req_payment};
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_SORT: begin
                     i_in      = '0;
                     ram_raddr = '0;
                  end
                  CMD_LOOKUP: begin
                     key_in    = req_order_key;
                     lo_in     = '0;
                     hi_in     = count_ff;
                     mid_in    = first_sum[IDX_W:1];
                     ram_raddr = first_sum[IDX_W:1];
                     if (count_ff == '0) begin
                        res_in.status = STAT_MISS;
                     end
                  end
               endcase
            end
         end
         ST_SORT_CUR: begin
            // hold entry i and start streaming k = i + 1 onward
            cur_in    = rd_rec;
            k_in      = i_ff + IDX_W'(1);
            ram_raddr = i_ff + IDX_W'(1);
         end
         ST_SORT_CMP: begin
            if (sort_swap) begin
               ram_we    = 1'b1;
               ram_waddr = k_ff;
               ram_wdata = REC_W'(cur_ff);
               cur_in    = rd_rec;
            end
            if (!sort_last_k) begin
               k_in      = k_ff + IDX_W'(1);
               ram_raddr = k_ff + IDX_W'(1);
            end
         end
         ST_SORT_WB: begin
            ram_we    = 1'b1;
            ram_waddr = i_ff;
            ram_wdata = REC_W'(cur_ff);
            if (!sort_last_i) begin
               i_in      = i_ff + IDX_W'(1);
               ram_raddr = i_ff + IDX_W'(1);
            end
         end
         ST_LOOK: begin
            if (look_hit) begin
               res_in.status = STAT_OK;
               res_in.rec    = rd_rec;
            end else begin
               lo_in = lo_nx;
               hi_in = hi_nx;
               if (look_more) begin
                  mid_in    = mid_sum[IDX_W:1];
                  ram_raddr = mid_sum[IDX_W:1];
               end else begin
                  res_in        = '0;
                  res_in.status = STAT_MISS;
               end
            end
         end
         ST_RESP: ;
         default: ;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_RESP);
   assign res       = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      i_ff   <= i_in;
      k_ff   <= k_in;
      cur_ff <= cur_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      key_ff <= key_in;
      res_ff <= res_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_sort_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff != ST_IDLE) |-> (CNT_W'(ram_waddr) < count_ff))
      else $error("sort writes beyond loaded entries");

   a_sort_pair_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SORT_CMP) |-> (k_ff > i_ff))
      else $error("sort compares a pair out of order");

   a_probe_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK) |-> (CNT_W'(mid_ff) >= lo_ff && CNT_W'(mid_ff) < hi_ff))
      else $error("lookup probe outside search window");

   a_count_stable_in_sort: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SORT_CMP || state_ff == ST_SORT_WB) |=> $stable(count_ff))
      else $error("entry count changed during sort");
`endif

endmodule

// ----- hdl/sorted_record_table_lookup.sv -----
// Record table with exchange sort and binary-search lookup. Holds up to
// TABLE_DEPTH records (signed key, tag, quantity, payment) in one simple dual-port
// synchronous RAM with one write and one registered read per cycle. Commands:
// clear drops all entries, load appends a record (status full when the table
// holds TABLE_DEPTH), sort orders the loaded entries by ascending signed key
// (unstable), lookup binary-searches the loaded entries and returns the record
// or status not found. One item is worked at a time and each gives one result.
// Clear and load are answered from the idle state; lookup reads its probes
// one at a time, and sort is paced by the single RAM read port that streams
// every pair i < k past the held record i. A finished result sits in an
// output register, so the next item is taken while the previous result
// waits for rsp_ready.
module sorted_record_table_lookup #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic signed [31:0] req_order_key,
   input  logic [15:0]        req_record_tag,
   input  logic [15:0]        req_quantity,
   input  logic [31:0]        req_payment,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_found_key,
   output logic [15:0]        rsp_found_tag,
   output logic [15:0]        rsp_found_quantity,
   output logic [31:0]        rsp_found_payment
);
   import srtl_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   logic [REC_W-1:0]  ram_wdata;
   logic [IDX_W-1:0]  ram_raddr;
   logic [REC_W-1:0]  ram_rdata;

   logic              res_valid;
   logic              res_ready;
   res_type           res;

   logic              rsp_valid_ff, rsp_valid_in;
   res_type           rsp_data_ff, rsp_data_in;

   // command sequencer: clear, load, sort passes and lookup probes
   srtl_seq #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_order_key  (req_order_key),
      .req_record_tag (req_record_tag),
      .req_quantity   (req_quantity),
      .req_payment    (req_payment),
      .res_valid      (res_valid),
      .res_ready      (res_ready),
      .res            (res),
      .ram_we         (ram_we),
      .ram_waddr      (ram_waddr),
      .ram_wdata      (ram_wdata),
      .ram_raddr      (ram_raddr),
      .ram_rdata      (ram_rdata)
   );

   // record store: key, tag, quantity and payment side by side in one word
   srtl_ram #(
      .WIDTH(REC_W),
      .DEPTH(TABLE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // output register: take a new result when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_data_ff.status;
   assign rsp_found_key      = rsp_data_ff.rec.key;
   assign rsp_found_tag      = rsp_data_ff.rec.tag;
   assign rsp_found_quantity = rsp_data_ff.rec.quantity;
   assign rsp_found_payment  = rsp_data_ff.rec.payment;

endmodule
